// File: rtl/pcmswc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// PCM sample width and channel converter package
// Register map, reset values and the default channel limit.
// ---------------------------------------------------------------------------
package pcmswc_pkg;

  localparam int unsigned MaxChannelsDefault = 8;

  // Register indexes, taken from paddr[4:2].
  localparam logic [2:0] RegInSampleBytes  = 3'd0;
  localparam logic [2:0] RegOutSampleBytes = 3'd1;
  localparam logic [2:0] RegInChannels     = 3'd2;
  localparam logic [2:0] RegOutChannels    = 3'd3;
  localparam logic [2:0] RegPacketBytes    = 3'd4;

  localparam logic [2:0]  InSampleBytesReset  = 3'd2;
  localparam logic [2:0]  OutSampleBytesReset = 3'd2;
  localparam logic [3:0]  InChannelsReset     = 4'd2;
  localparam logic [3:0]  OutChannelsReset    = 4'd2;
  localparam logic [15:0] PacketBytesReset    = 16'd4096;

  localparam logic [2:0] SampleBytesMax = 3'd4;

endpackage

// File: rtl/pcm_sample_width_channel_converter.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// PCM sample width and channel converter
// Converts interleaved signed PCM samples between byte widths and channel
// counts, and marks the frames that close an output packet.
// ---------------------------------------------------------------------------
// Usage:
// The input channel takes one raw sample per request (in_valid_i/in_stall_o).
// Each request yields zero results (dropped channel), one result, or, on the
// frame's last input channel, one result per remaining output channel. The
// output channel (out_valid_o/out_stall_i) carries one converted sample per
// request together with its channel index and run/packet markers.
// Inputs reach the output via the run and output registers. The block takes
// one input per cycle while the output does not stall and each request yields
// at most one result; a request with more results holds the input side while
// the run register emits them, one per cycle into the output register unless
// stalled. The output register parts the two sides, so a new input is taken
// in the same cycle the last result of the previous run moves to the output.
// When out_stall_i is high the output register holds; the run register
// then holds and in_stall_o rises once a run is pending. Reset clears the
// run and output valid flags, the channel index and the packet byte count,
// and restores the register reset values. The user must write registers via
// the APB-style port only while idle; the block does not enforce it.
// ---------------------------------------------------------------------------
module pcm_sample_width_channel_converter
  import pcmswc_pkg::*;
#(
  parameter int unsigned MAX_CHANNELS = MaxChannelsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] in_sample_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] out_sample_o,
  output logic [2:0]  out_channel_o,
  output logic        run_last_o,
  output logic        packet_last_o
);

  localparam int unsigned IdxW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned CntW = $clog2(MAX_CHANNELS + 1);

  // Configuration registers.
  logic [2:0]  in_bytes_q, out_bytes_q;
  logic [3:0]  in_ch_q, out_ch_q;
  logic [15:0] pkt_bytes_q;

  logic       cfg_wr;
  logic [2:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_bytes_q  <= InSampleBytesReset;
      out_bytes_q <= OutSampleBytesReset;
      in_ch_q     <= InChannelsReset;
      out_ch_q    <= OutChannelsReset;
      pkt_bytes_q <= PacketBytesReset;
    end else if (cfg_wr) begin
      case (cfg_idx)
        RegInSampleBytes:  in_bytes_q  <= pwdata[2:0];
        RegOutSampleBytes: out_bytes_q <= pwdata[2:0];
        RegInChannels:     in_ch_q     <= pwdata[3:0];
        RegOutChannels:    out_ch_q    <= pwdata[3:0];
        RegPacketBytes:    pkt_bytes_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      RegInSampleBytes:  prdata = 32'(in_bytes_q);
      RegOutSampleBytes: prdata = 32'(out_bytes_q);
      RegInChannels:     prdata = 32'(in_ch_q);
      RegOutChannels:    prdata = 32'(out_ch_q);
      RegPacketBytes:    prdata = 32'(pkt_bytes_q);
      default:           prdata = 32'd0;
    endcase
  end

  // Effective settings with out-of-range values folded into range.
  logic [2:0]      ib, ob;
  logic [CntW-1:0] ic, oc;
  logic [15:0]     pb;

  always_comb begin
    ib = (in_bytes_q == 3'd0) ? 3'd1 :
         (in_bytes_q > SampleBytesMax) ? SampleBytesMax : in_bytes_q;
    ob = (out_bytes_q == 3'd0) ? 3'd1 :
         (out_bytes_q > SampleBytesMax) ? SampleBytesMax : out_bytes_q;
    ic = (in_ch_q == 4'd0) ? CntW'(1) :
         (32'(in_ch_q) > MAX_CHANNELS) ? CntW'(MAX_CHANNELS) : CntW'(in_ch_q);
    oc = (out_ch_q == 4'd0) ? CntW'(1) :
         (32'(out_ch_q) > MAX_CHANNELS) ? CntW'(MAX_CHANNELS) : CntW'(out_ch_q);
    pb = (pkt_bytes_q == 16'd0) ? 16'd1 : pkt_bytes_q;
  end

  // Step state.
  logic [IdxW-1:0] in_idx_q, in_idx_d;
  logic [16:0]     pkt_cnt_q, pkt_cnt_d;

  // Run register: one accepted item that still has results to emit.
  logic            run_valid_q, run_valid_d;
  logic [31:0]     run_sample_q, run_sample_d;
  logic [IdxW-1:0] run_ch_q, run_ch_d;
  logic [IdxW-1:0] run_end_q, run_end_d;
  logic            run_pkt_q, run_pkt_d;

  // Output register.
  logic        out_valid_q, out_valid_d;
  logic [31:0] out_sample_q;
  logic [2:0]  out_channel_q;
  logic        out_run_last_q, out_pkt_last_q;

  logic emit, run_done, in_accept;

  assign emit      = run_valid_q && (!out_valid_q || !out_stall_i);
  assign run_done  = emit && (run_ch_q == run_end_q);
  assign in_stall_o = run_valid_q && !run_done;
  assign in_accept = in_valid_i && !in_stall_o;

  // Per-item step logic.
  logic [IdxW-1:0] j, last_ch, oc_last;
  logic [CntW-1:0] ic_m1;
  logic            is_last_in, has_result, frame_done;
  logic [4:0]      up_sh, down_sh;
  logic [31:0]     aligned, converted;
  logic [16:0]     frame_bytes, cnt_sum;
  logic            pkt_close;

  always_comb begin
    j       = (CntW'(in_idx_q) >= ic) ? '0 : in_idx_q;
    ic_m1   = ic - CntW'(1);
    oc_last = IdxW'(oc - CntW'(1));
    is_last_in = (CntW'(j) == ic_m1);
    has_result = (CntW'(j) < oc);
    // The frame's last input channel also fills the channels it lacks.
    last_ch    = (is_last_in && (oc > ic)) ? oc_last : j;
    frame_done = has_result && (last_ch == oc_last);

    up_sh     = {2'(SampleBytesMax - ib), 3'b000};
    down_sh   = {2'(SampleBytesMax - ob), 3'b000};
    aligned   = in_sample_i << up_sh;
    converted = 32'($signed(aligned) >>> down_sh);

    frame_bytes = 17'(oc) * 17'(ob);
    cnt_sum     = pkt_cnt_q + frame_bytes;
    pkt_close   = frame_done && (cnt_sum >= 17'(pb));
  end

  always_comb begin
    in_idx_d     = in_idx_q;
    pkt_cnt_d    = pkt_cnt_q;
    run_valid_d  = run_valid_q;
    run_sample_d = run_sample_q;
    run_ch_d     = run_ch_q;
    run_end_d    = run_end_q;
    run_pkt_d    = run_pkt_q;

    if (run_done) begin
      run_valid_d = 1'b0;
    end else if (emit) begin
      run_ch_d = run_ch_q + IdxW'(1);
    end

    if (in_accept) begin
      in_idx_d = is_last_in ? '0 : j + IdxW'(1);
      if (frame_done) begin
        pkt_cnt_d = pkt_close ? 17'd0 : cnt_sum;
      end
      if (has_result) begin
        run_valid_d  = 1'b1;
        run_sample_d = converted;
        run_ch_d     = j;
        run_end_d    = last_ch;
        run_pkt_d    = pkt_close;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_idx_q    <= '0;
      pkt_cnt_q   <= 17'd0;
      run_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_idx_q    <= in_idx_d;
      pkt_cnt_q   <= pkt_cnt_d;
      run_valid_q <= run_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    run_sample_q <= run_sample_d;
    run_ch_q     <= run_ch_d;
    run_end_q    <= run_end_d;
    run_pkt_q    <= run_pkt_d;
    if (emit) begin
      out_sample_q   <= run_sample_q;
      out_channel_q  <= 3'(run_ch_q);
      out_run_last_q <= (run_ch_q == run_end_q);
      out_pkt_last_q <= run_pkt_q && (run_ch_q == run_end_q);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_sample_o  = out_sample_q;
  assign out_channel_o = out_channel_q;
  assign run_last_o    = out_run_last_q;
  assign packet_last_o = out_pkt_last_q;

  // The input side only waits on a pending run.
  a_stall_needs_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> run_valid_q)
    else $error("input stalled without a pending run");

  // A pending run never steps past its final channel.
  a_run_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_valid_q |-> (run_ch_q <= run_end_q))
    else $error("run channel beyond its end");

  // A packet can close only on the final result of an item.
  a_pkt_on_run_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && packet_last_o) |-> run_last_o)
    else $error("packet_last without run_last");

  // Inside a run, results follow back to back on consecutive channels.
  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !run_last_o) |=>
      (out_valid_o && (out_channel_o == 3'($past(out_channel_o) + 3'd1))))
    else $error("run interrupted or channel skipped");

endmodule
